// ===== sv/bmhpq_pkg.sv =====
// Shared types for the binary max-heap priority queue: heap entry layout,
// controller state codes and the command/status bundles between controller
// and datapath. No dependencies.
package bmhpq_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned InDataW         = 48;
  localparam int unsigned ResultBaseW     = 42;

  typedef struct packed {
    logic [15:0] pages;
    logic [15:0] job;
    logic [7:0]  prio;
  } entry_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_UP    = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_DOWN  = 6'b001000,
    ST_PLACE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic up;
    logic load;
    logic down;
    logic place;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic up_swap;
    logic up_more;
    logic root_kids;
    logic down_swap;
    logic down_more;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/binary_max_heap_priority_queue.sv =====
// Binary max-heap of print jobs behind a stream handshake. Each input transaction
// inserts or removes one job and yields exactly one result transaction with the
// root entry, the count and a drop flag. A refused insert or a remove from an empty
// heap passes through accept and the result register load. An insert passes through
// accept, one sift-up step per heap level climbed (at least one unless the heap was
// empty), placement of the new entry and the result register load. A remove passes
// through accept, a fetch of the last entry, one sift-down step per level descended,
// placement of the moving entry and the result register load; removing the only job
// skips the placement. The next transaction is accepted in the cycle after the result
// register loads.
// The pace is set by the entry memory, which is read through registered
// ports and written at one address per cycle, so the sift advances one level per
// cycle. A new transaction is taken while the previous result waits downstream;
// its result register load then waits until that result is taken.
// Depends on bmhpq_pkg, bmhpq_ctrl and bmhpq_dp.
module binary_max_heap_priority_queue import bmhpq_pkg::*; #(
  parameter  int unsigned HEAP_CAPACITY = DefaultCapacity,
  localparam int unsigned CntW          = $clog2(HEAP_CAPACITY + 1),
  localparam int unsigned OutDataW      = ((ResultBaseW + CntW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // operation, job_priority, job_number, page_count
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // top_valid, top_priority, top_job_number, top_page_count, entry_count,
  // insert_dropped
  output logic [OutDataW-1:0] m_axis_tdata
);

  cmd_t            cmd;
  sts_t            sts;
  entry_t          in_entry, out_top;
  op_e             in_op;
  logic            out_top_valid, out_dropped;
  logic [CntW-1:0] out_count;

  assign in_op          = op_e'(s_axis_tdata[0]);
  assign in_entry.prio  = s_axis_tdata[8:1];
  assign in_entry.job   = s_axis_tdata[24:9];
  assign in_entry.pages = s_axis_tdata[40:25];

  bmhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmhpq_dp #(
    .HEAP_CAPACITY (HEAP_CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_op_i         (in_op),
    .in_entry_i      (in_entry),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_top_valid_o (out_top_valid),
    .out_top_o       (out_top),
    .out_count_o     (out_count),
    .out_dropped_o   (out_dropped)
  );

  assign m_axis_tdata = OutDataW'({out_dropped, out_count, out_top.pages, out_top.job,
                                   out_top.prio, out_top_valid});

endmodule

// ===== sv/bmhpq_ctrl.sv =====
// Controller state machine of the heap queue: sequences accept, sift-up,
// last-entry load, sift-down, placement and result hand-off.
// Depends on bmhpq_pkg.
module bmhpq_ctrl import bmhpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_remove) begin
            state_d = sts_i.empty ? ST_OUT : ST_LOAD;
          end else if (sts_i.full) begin
            state_d = ST_OUT;
          end else if (sts_i.empty) begin
            state_d = ST_PLACE;
          end else begin
            state_d = ST_UP;
          end
        end
      end
      ST_UP: begin
        cmd_o.up = 1'b1;
        state_d  = (sts_i.up_swap && sts_i.up_more) ? ST_UP : ST_PLACE;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        if (sts_i.empty) begin
          state_d = ST_OUT;
        end else if (sts_i.root_kids) begin
          state_d = ST_DOWN;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_DOWN: begin
        cmd_o.down = 1'b1;
        state_d    = (sts_i.down_swap && sts_i.down_more) ? ST_DOWN : ST_PLACE;
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/bmhpq_dp.sv =====
// Datapath of the heap queue: entry memory with two registered read ports,
// moving-entry and hole registers, occupancy count, root shadow and result
// register. Depends on bmhpq_pkg.
module bmhpq_dp import bmhpq_pkg::*; #(
  parameter  int unsigned HEAP_CAPACITY = DefaultCapacity,
  localparam int unsigned CntW          = $clog2(HEAP_CAPACITY + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  op_e             in_op_i,
  input  entry_t          in_entry_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic            out_top_valid_o,
  output entry_t          out_top_o,
  output logic [CntW-1:0] out_count_o,
  output logic            out_dropped_o
);

  localparam int unsigned IdxW = $clog2(HEAP_CAPACITY);
  localparam int unsigned PosW = IdxW + 2;

  entry_t mem [HEAP_CAPACITY];
  entry_t rd_a_q, rd_b_q, item_q, root_q, wdata, best;
  entry_t out_top_q;

  logic [IdxW-1:0] hole_q, ra, rb, pidx, bidx;
  logic [CntW-1:0] cnt_q, out_count_q;
  logic [PosW-1:0] cnt_w, hole_w, lidx, ridx, bidx_w, nlidx, nridx;
  logic            right_ok, take_right, we, full, empty, up_swap, down_swap, down_more;
  logic            dropped_q, out_valid_q, out_top_valid_q, out_dropped_q;

  assign full   = (cnt_q == CntW'(HEAP_CAPACITY));
  assign empty  = (cnt_q == '0);
  assign cnt_w  = PosW'(cnt_q);
  assign hole_w = PosW'(hole_q);

  assign pidx    = (hole_q - IdxW'(1)) >> 1;
  assign up_swap = (item_q.prio > rd_a_q.prio);

  assign lidx       = (hole_w << 1) + PosW'(1);
  assign ridx       = lidx + PosW'(1);
  assign right_ok   = (ridx < cnt_w);
  assign take_right = right_ok && (rd_b_q.prio > rd_a_q.prio);
  assign best       = take_right ? rd_b_q : rd_a_q;
  assign bidx_w     = take_right ? ridx : lidx;
  assign bidx       = bidx_w[IdxW-1:0];
  assign nlidx      = (bidx_w << 1) + PosW'(1);
  assign nridx      = nlidx + PosW'(1);
  assign down_swap  = (best.prio > item_q.prio);
  assign down_more  = (nlidx < cnt_w);

  assign sts_o.is_remove = (in_op_i == OP_REMOVE);
  assign sts_o.full      = full;
  assign sts_o.empty     = empty;
  assign sts_o.up_swap   = up_swap;
  assign sts_o.up_more   = (pidx != '0);
  assign sts_o.root_kids = (cnt_q > CntW'(1));
  assign sts_o.down_swap = down_swap;
  assign sts_o.down_more = down_more;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    ra = '0;
    rb = '0;
    if (cmd_i.accept) begin
      if (in_op_i == OP_REMOVE) begin
        if (!empty) begin
          ra = IdxW'(cnt_q - CntW'(1));
        end
      end else if (!empty && !full) begin
        ra = IdxW'((cnt_q - CntW'(1)) >> 1);
      end
    end else if (cmd_i.up) begin
      ra = (pidx - IdxW'(1)) >> 1;
    end else if (cmd_i.load) begin
      ra = IdxW'(1);
      rb = (cnt_q > CntW'(2)) ? IdxW'(2) : IdxW'(1);
    end else if (cmd_i.down && down_more) begin
      ra = nlidx[IdxW-1:0];
      rb = (nridx < cnt_w) ? nridx[IdxW-1:0] : nlidx[IdxW-1:0];
    end
  end

  assign we    = (cmd_i.up && up_swap) || (cmd_i.down && down_swap) || cmd_i.place;
  assign wdata = cmd_i.place ? item_q : (cmd_i.up ? rd_a_q : best);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[hole_q] <= wdata;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (in_op_i == OP_REMOVE) begin
        hole_q <= '0;
      end else begin
        item_q <= in_entry_i;
        hole_q <= IdxW'(cnt_q);
      end
      dropped_q <= (in_op_i == OP_INSERT) && full;
    end
    if (cmd_i.up && up_swap) begin
      hole_q <= pidx;
    end
    if (cmd_i.down && down_swap) begin
      hole_q <= bidx;
    end
    if (cmd_i.load) begin
      item_q <= rd_a_q;
    end
    if (we && (hole_q == '0)) begin
      root_q <= wdata;
    end
    if (cmd_i.emit) begin
      out_top_valid_q <= !empty;
      out_top_q       <= empty ? '0 : root_q;
      out_count_q     <= cnt_q;
      out_dropped_q   <= dropped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (in_op_i == OP_REMOVE) begin
          if (!empty) begin
            cnt_q <= cnt_q - CntW'(1);
          end
        end else if (!full) begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_top_valid_o = out_top_valid_q;
  assign out_top_o       = out_top_q;
  assign out_count_o     = out_count_q;
  assign out_dropped_o   = out_dropped_q;

  a_drop_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && (in_op_i == OP_INSERT) && full |=> $stable(cnt_q))
    else $error("refused insert changed the count");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("result not presented after emit");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  a_up_below_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.up |-> (hole_q != '0))
    else $error("sift-up step at the root");

  a_top_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_top_valid_q == (out_count_q != '0)))
    else $error("top valid disagrees with count");

endmodule

// ===== tb/tb_binary_max_heap_priority_queue.sv =====
// Testbench for binary_max_heap_priority_queue: a directed table and random job traffic,
// checked field by field against a shadow max-heap kept in the testbench, or for typed
// table rows against the status in the row. Depends on bmhpq_pkg and the block's RTL.
module tb_binary_max_heap_priority_queue;
  import bmhpq_pkg::*;

  localparam int unsigned Cap      = 16;
  localparam int unsigned CntW     = $clog2(Cap + 1);
  localparam int unsigned OutW     = ((ResultBaseW + CntW + 7) / 8) * 8;
  localparam int unsigned CycLimit = 200000;
  localparam int unsigned HoldLen  = 400;

  typedef struct packed {
    logic            dropped;
    logic [CntW-1:0] count;
    logic [15:0]     pages;
    logic [15:0]     job;
    logic [7:0]      prio;
    logic            valid;
  } heap_status_t;

  typedef struct {
    op_e          op;
    entry_t       job;
    logic         typed;
    heap_status_t want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;

  entry_t          shadow_heap [Cap];
  int unsigned     shadow_fill;
  heap_status_t    top_status_q [$];
  stim_row_t       dir_rows [$];

  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  bit          hold_request  = 1'b0;
  int unsigned err_count     = 0;
  int unsigned n_sent        = 0;
  int unsigned n_seen        = 0;
  int unsigned n_drops       = 0;
  int unsigned n_empty_rm    = 0;
  int unsigned peak_fill     = 0;
  int unsigned cyc           = 0;

  int unsigned ins_bias  [7] = '{70, 30, 85, 15, 50, 75, 25};
  int unsigned snd_modes [4] = '{0, 53, 0, 22};
  int unsigned rcv_modes [4] = '{0, 0, 53, 22};

  binary_max_heap_priority_queue #(
    .HEAP_CAPACITY(Cap)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic heap_status_t job_heap_step(op_e op, entry_t e);
    heap_status_t r;
    int unsigned  pos;
    int unsigned  par;
    int unsigned  lc;
    int unsigned  best;
    entry_t       t;
    r = '0;
    if (op == OP_INSERT) begin
      if (shadow_fill >= Cap) begin
        r.dropped = 1'b1;
      end else begin
        pos = shadow_fill;
        shadow_heap[pos] = e;
        shadow_fill++;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (shadow_heap[pos].prio <= shadow_heap[par].prio) break;
          t = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[par];
          shadow_heap[par] = t;
          pos = par;
        end
      end
    end else if (shadow_fill > 0) begin
      shadow_fill--;
      shadow_heap[0] = shadow_heap[shadow_fill];
      pos = 0;
      while (2 * pos + 1 < shadow_fill) begin
        lc = 2 * pos + 1;
        best = lc;
        if (lc + 1 < shadow_fill && shadow_heap[lc + 1].prio > shadow_heap[lc].prio) begin
          best = lc + 1;
        end
        if (shadow_heap[best].prio <= shadow_heap[pos].prio) break;
        t = shadow_heap[pos];
        shadow_heap[pos] = shadow_heap[best];
        shadow_heap[best] = t;
        pos = best;
      end
    end
    if (shadow_fill > 0) begin
      r.valid = 1'b1;
      r.prio  = shadow_heap[0].prio;
      r.job   = shadow_heap[0].job;
      r.pages = shadow_heap[0].pages;
    end
    r.count = CntW'(shadow_fill);
    return r;
  endfunction

  function automatic stim_row_t mk_row(op_e op, logic [7:0] p, logic [15:0] j,
                                       logic [15:0] g, logic typed, heap_status_t want);
    stim_row_t r;
    r.op        = op;
    r.job.prio  = p;
    r.job.job   = j;
    r.job.pages = g;
    r.typed     = typed;
    r.want      = want;
    return r;
  endfunction

  function automatic heap_status_t mk_status(logic v, logic [7:0] p, logic [15:0] j,
                                             logic [15:0] g, int unsigned c, logic d);
    heap_status_t s;
    s.valid   = v;
    s.prio    = p;
    s.job     = j;
    s.pages   = g;
    s.count   = CntW'(c);
    s.dropped = d;
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)", what, got, want, n_seen);
    err_count++;
  endtask

  // Offer one job, hold it until it is accepted, then predict.
  task automatic send_job(stim_row_t row);
    heap_status_t pred;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - 41){1'b0}}, row.job.pages, row.job.job, row.job.prio,
                      row.op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (row.op == OP_REMOVE && shadow_fill == 0) n_empty_rm++;
    pred = job_heap_step(row.op, row.job);
    top_status_q.push_back(row.typed ? row.want : pred);
    if (pred.dropped) n_drops++;
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    n_sent++;
  endtask

  initial begin
    int unsigned hold_cnt;
    heap_status_t got;
    heap_status_t want;
    hold_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = heap_status_t'(m_axis_tdata[$bits(heap_status_t)-1:0]);
        if (top_status_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(got), 32'h0);
        end else begin
          want = top_status_q.pop_front();
          if (got.valid !== want.valid) begin
            report_mismatch("top_valid", 32'(got.valid), 32'(want.valid));
          end
          if (got.prio !== want.prio) begin
            report_mismatch("top_priority", 32'(got.prio), 32'(want.prio));
          end
          if (got.job !== want.job) begin
            report_mismatch("top_job_number", 32'(got.job), 32'(want.job));
          end
          if (got.pages !== want.pages) begin
            report_mismatch("top_page_count", 32'(got.pages), 32'(want.pages));
          end
          if (got.count !== want.count) begin
            report_mismatch("entry_count", 32'(got.count), 32'(want.count));
          end
          if (got.dropped !== want.dropped) begin
            report_mismatch("insert_dropped", 32'(got.dropped), 32'(want.dropped));
          end
        end
        n_seen++;
      end
      if (hold_request) begin
        hold_cnt = HoldLen;
        hold_request = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  initial begin
    while (cyc < CycLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d results pending", cyc, top_status_q.size());
    $display("binary_max_heap_priority_queue verification failed");
    $finish;
  end

  initial begin
    stim_row_t   row;
    int unsigned r;
    rst_ni = 1'b0;
    shadow_fill = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows.push_back(mk_row(OP_REMOVE, 8'h00, 16'h0000, 16'h0000, 1'b1,
                              mk_status(1'b0, 8'h00, 16'h0000, 16'h0000, 0, 1'b0)));
    dir_rows.push_back(mk_row(OP_INSERT, 8'h00, 16'h0000, 16'h0000, 1'b1,
                              mk_status(1'b1, 8'h00, 16'h0000, 16'h0000, 1, 1'b0)));
    dir_rows.push_back(mk_row(OP_REMOVE, 8'h00, 16'hffff, 16'hffff, 1'b1,
                              mk_status(1'b0, 8'h00, 16'h0000, 16'h0000, 0, 1'b0)));
    dir_rows.push_back(mk_row(OP_INSERT, 8'hff, 16'hffff, 16'hffff, 1'b1,
                              mk_status(1'b1, 8'hff, 16'hffff, 16'hffff, 1, 1'b0)));
    // equal priority stays below its parent
    dir_rows.push_back(mk_row(OP_INSERT, 8'hff, 16'h0001, 16'h0001, 1'b1,
                              mk_status(1'b1, 8'hff, 16'hffff, 16'hffff, 2, 1'b0)));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd100, 16'h5555, 16'haaaa, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd100, 16'haaaa, 16'h5555, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd100, 16'h8000, 16'h0001, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd50, 16'h0001, 16'h8000, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd50, 16'h1111, 16'h2222, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd200, 16'h3333, 16'h4444, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd200, 16'h5678, 16'h9abc, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd7, 16'hffff, 16'h0000, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd0, 16'h0000, 16'hffff, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd254, 16'hfedc, 16'hba98, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd128, 16'h7fff, 16'h7fff, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd128, 16'h0f0f, 16'hf0f0, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd1, 16'h00ff, 16'hff00, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'd100, 16'h0102, 16'h0304, 1'b0, '0));
    // heap is full now: the insert is refused
    dir_rows.push_back(mk_row(OP_INSERT, 8'hff, 16'h1234, 16'h4321, 1'b1,
                              mk_status(1'b1, 8'hff, 16'hffff, 16'hffff, Cap, 1'b1)));
    repeat (5) dir_rows.push_back(mk_row(OP_REMOVE, 8'h00, 16'h0000, 16'h0000, 1'b0, '0));

    foreach (dir_rows[i]) send_job(dir_rows[i]);

    for (int seg = 0; seg < 7; seg++) begin
      snd_idle_pct  = snd_modes[seg % 4];
      rcv_stall_pct = rcv_modes[seg % 4];
      if (seg == 2) hold_request = 1'b1;
      if (seg == 4) begin
        s_axis_tvalid <= 1'b0;
        while (top_status_q.size() != 0) @(posedge clk_i);
      end
      for (int i = 0; i < 100; i++) begin
        row.op = ($urandom_range(0, 99) < ins_bias[seg]) ? OP_INSERT : OP_REMOVE;
        r = $urandom_range(0, 5);
        if (r < 2) row.job.prio = 8'($urandom_range(0, 3));
        else if (r == 2) row.job.prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
        else row.job.prio = 8'($urandom);
        row.job.job   = 16'($urandom);
        row.job.pages = 16'($urandom);
        row.typed     = 1'b0;
        row.want      = '0;
        send_job(row);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (top_status_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (top_status_q.size() != 0) begin
      report_mismatch("results left over", 32'(top_status_q.size()), 32'h0);
    end
    $display("covered %0d transactions and %0d results, %0d refused inserts, %0d empty removes",
             n_sent, n_seen, n_drops, n_empty_rm);
    $display("peak heap fill %0d of %0d, %0d mismatches", peak_fill, Cap, err_count);
    if (err_count == 0) begin
      $display("binary_max_heap_priority_queue verification clean");
    end else begin
      $display("binary_max_heap_priority_queue verification failed");
    end
    $finish;
  end

endmodule
